[src/ofmt_pkg.sv]
// Shared types and constants for the octal field formatter.
// No dependencies; imported by every module of the block.
package ofmt_pkg;

    // Octal digits in a 32-bit value, and the index width for them
    localparam int unsigned DIGIT_N = 11;
    localparam int unsigned DIG_W   = 4;
    localparam int unsigned LEN_W   = 6;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes
    localparam logic [2:0] REG_FIELD_WIDTH  = 3'd0;
    localparam logic [2:0] REG_MIN_DIGITS   = 3'd1;
    localparam logic [2:0] REG_ZERO_PAD     = 3'd2;
    localparam logic [2:0] REG_LEFT_JUSTIFY = 3'd3;
    localparam logic [2:0] REG_ALT_FORM     = 3'd4;

    // Layout of one field, positions counted from the first character.
    // Digits fill [dig_start, digit_end), extra zeros [core_start, dig_start),
    // everything else is padding.
    typedef struct packed {
        logic [31:0]      value;
        logic [LEN_W-1:0] total;
        logic [LEN_W-1:0] digit_end;
        logic [LEN_W-1:0] core_start;
        logic [LEN_W-1:0] dig_start;
        logic [7:0]       pad_char;
    } t_desc;

endpackage

[src/ofmt_front.sv]
// Front end: works out the layout of one field from the value and config.
// Depends on ofmt_pkg.
module ofmt_front
    import ofmt_pkg::*;
#(
    parameter int unsigned MAX_FIELD = 63
) (
    input  logic [31:0]      i_value,
    input  logic [LEN_W-1:0] i_field_width,
    input  logic [LEN_W-1:0] i_min_digits,
    input  logic             i_zero_pad,
    input  logic             i_left_justify,
    input  logic             i_alt_form,
    output t_desc            o_desc
);

    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_FIELD);

    logic [DIG_W-1:0] w_nd;
    logic [LEN_W-1:0] w_core_raw;
    logic [LEN_W-1:0] w_md;
    logic [LEN_W-1:0] w_core;
    logic [LEN_W-1:0] w_width;
    logic [LEN_W-1:0] w_total;
    logic [LEN_W-1:0] w_end;

    // digit count: position of the highest nonzero octal digit, at least one
    always_comb begin
        w_nd = DIG_W'(1);
        for (int i = 1; i < DIGIT_N; i++) begin
            if ((i_value >> (3 * i)) != 32'd0) begin
                w_nd = DIG_W'(i + 1);
            end
        end
    end

    // digit text length with alternate form and precision, then the field length
    always_comb begin
        w_core_raw = LEN_W'(w_nd) + LEN_W'(i_alt_form && (i_value != 32'd0));
        w_md       = (i_min_digits > MaxLen) ? MaxLen : i_min_digits;
        w_core     = (w_core_raw > w_md) ? w_core_raw : w_md;
        w_core     = (w_core > MaxLen) ? MaxLen : w_core;
        w_width    = (i_field_width > MaxLen) ? MaxLen : i_field_width;
        w_total    = (w_width > w_core) ? w_width : w_core;
        w_end      = i_left_justify ? w_core : w_total;
    end

    // field layout
    always_comb begin
        o_desc.value      = i_value;
        o_desc.total      = w_total;
        o_desc.digit_end  = w_end;
        o_desc.core_start = w_end - w_core;
        o_desc.dig_start  = w_end - LEN_W'(w_nd);
        o_desc.pad_char   = (i_zero_pad && !i_left_justify) ? CH_ZERO : CH_SPACE;
    end

endmodule

[src/ofmt_dq.sv]
// Two-entry layout queue between front end and character generator.
// Depends on ofmt_pkg.
module ofmt_dq
    import ofmt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_desc o_rdata,
    output logic  o_empty
);

    t_desc      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rdata = r_mem[r_rp];

    // occupancy
    always_comb begin
        n_cnt = r_cnt + 2'(i_wr) - 2'(i_rd);
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (i_rd) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

[src/ofmt_back.sv]
// Character generator: walks one field layout a character per cycle into
// a two-word output queue, stalling while that queue is full and not popped. Depends on ofmt_pkg.
module ofmt_back
    import ofmt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_desc            i_desc,
    input  logic             i_desc_empty,
    output logic             o_desc_rd,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [7:0]       o_char_code,
    output logic             o_is_last,
    output logic [LEN_W-1:0] o_total_length
);

    t_desc            r_d;
    logic             r_busy;
    logic [LEN_W-1:0] r_pos;

    logic [7:0]       r_oq_ch   [2];
    logic             r_oq_last [2];
    logic [LEN_W-1:0] r_oq_len  [2];
    logic             r_owp;
    logic             r_orp;
    logic [1:0]       r_ocnt;

    logic             w_room;
    logic             w_emit;
    logic             w_fin;
    logic             w_rd;
    logic [LEN_W-1:0] w_idx;
    logic [LEN_W-1:0] w_shift;
    logic [2:0]       w_digit;
    logic [7:0]       w_ch;

    // handshake between generator and output queue
    assign w_rd      = i_pop && (r_ocnt != 2'd0);
    assign w_room    = (r_ocnt != 2'd2) || i_pop;
    assign w_emit    = r_busy && w_room;
    assign w_fin     = w_emit && (r_pos == r_d.total - LEN_W'(1));
    assign o_desc_rd = !i_desc_empty && (!r_busy || w_fin);

    // character at the current position
    always_comb begin
        w_idx   = r_d.digit_end - LEN_W'(1) - r_pos;
        w_shift = LEN_W'(w_idx[DIG_W-1:0]) * LEN_W'(3);
        w_digit = 3'(r_d.value >> w_shift);
        if (r_pos >= r_d.dig_start && r_pos < r_d.digit_end) begin
            w_ch = CH_ZERO + 8'(w_digit);
        end else if (r_pos >= r_d.core_start && r_pos < r_d.digit_end) begin
            w_ch = CH_ZERO;
        end else begin
            w_ch = r_d.pad_char;
        end
    end

    // field walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
        end else if (o_desc_rd) begin
            r_busy <= 1'b1;
            r_pos  <= '0;
        end else if (w_fin) begin
            r_busy <= 1'b0;
        end else if (w_emit) begin
            r_pos <= r_pos + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_desc_rd) begin
            r_d <= i_desc;
        end
    end

    // output queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_emit) r_owp <= ~r_owp;
            if (w_rd)   r_orp <= ~r_orp;
            r_ocnt <= r_ocnt + 2'(w_emit) - 2'(w_rd);
        end
    end

    // output queue words
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_oq_ch[r_owp]   <= w_ch;
            r_oq_last[r_owp] <= w_fin;
            r_oq_len[r_owp]  <= w_fin ? r_d.total : '0;
        end
    end

    assign o_empty        = (r_ocnt == 2'd0);
    assign o_char_code    = r_oq_ch[r_orp];
    assign o_is_last      = r_oq_last[r_orp];
    assign o_total_length = r_oq_len[r_orp];

endmodule

[src/octal_field_formatter.sv]
// Top level of the printf-style octal field formatter.
// Depends on ofmt_pkg, ofmt_front, ofmt_dq and ofmt_back.
//
// Each pushed 32-bit value comes out as its formatted octal text, one ASCII
// character per popped word; the final word has o_is_last set and carries the
// field length of 1 to MAX_FIELD characters. The character generator emits one
// character per cycle while the output queue has room, and the next field's
// first character follows at once when its layout is already waiting. A
// two-entry layout queue lets up to two further values be pushed while a field
// is being emitted. Configuration is sampled when a value is pushed.
module octal_field_formatter
    import ofmt_pkg::*;
#(
    parameter int unsigned MAX_FIELD = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data,
    input  logic             push,
    output logic             full,
    input  logic [31:0]      i_value,
    output logic             empty,
    input  logic             pop,
    output logic [7:0]       o_char_code,
    output logic             o_is_last,
    output logic [LEN_W-1:0] o_total_length
);

    logic [LEN_W-1:0] r_field_width;
    logic [LEN_W-1:0] r_min_digits;
    logic             r_zero_pad;
    logic             r_left_justify;
    logic             r_alt_form;

    t_desc w_desc;
    t_desc w_q_desc;
    logic  w_q_empty;
    logic  w_q_rd;
    logic  w_push;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_width  <= '0;
            r_min_digits   <= '0;
            r_zero_pad     <= 1'b0;
            r_left_justify <= 1'b0;
            r_alt_form     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIELD_WIDTH:  r_field_width  <= i_cfg_data;
                REG_MIN_DIGITS:   r_min_digits   <= i_cfg_data;
                REG_ZERO_PAD:     r_zero_pad     <= i_cfg_data[0];
                REG_LEFT_JUSTIFY: r_left_justify <= i_cfg_data[0];
                REG_ALT_FORM:     r_alt_form     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_push = push && !full;

    // layout of the incoming value
    ofmt_front #(
        .MAX_FIELD (MAX_FIELD)
    ) u_front (
        .i_value        (i_value),
        .i_field_width  (r_field_width),
        .i_min_digits   (r_min_digits),
        .i_zero_pad     (r_zero_pad),
        .i_left_justify (r_left_justify),
        .i_alt_form     (r_alt_form),
        .o_desc         (w_desc)
    );

    // layouts waiting for the generator
    ofmt_dq u_dq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_push),
        .i_wdata (w_desc),
        .o_full  (full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_desc),
        .o_empty (w_q_empty)
    );

    // character generation and output queue
    ofmt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_desc         (w_q_desc),
        .i_desc_empty   (w_q_empty),
        .o_desc_rd      (w_q_rd),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_char_code    (o_char_code),
        .o_is_last      (o_is_last),
        .o_total_length (o_total_length)
    );

endmodule

[tb/octal_field_formatter_test.sv]
// Self-checking testbench for octal_field_formatter.
// Depends on ofmt_pkg and the block's RTL; a built-in predictor formats each
// pushed value and every popped character word is checked against it.
`timescale 1ns / 100ps

module octal_field_formatter_test;
    import ofmt_pkg::*;

    localparam int FIELD_MAX   = 63;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYC  = 4;

    // One expected character word
    typedef struct {
        logic [7:0]       char_code;
        logic             is_last;
        logic [LEN_W-1:0] total_length;
    } t_char_word;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [2:0]       i_cfg_idx;
    logic [LEN_W-1:0] i_cfg_data;
    logic             push;
    logic             full;
    logic [31:0]      i_value;
    logic             empty;
    logic             pop = 1'b0;
    logic [7:0]       o_char_code;
    logic             o_is_last;
    logic [LEN_W-1:0] o_total_length;

    // Shadow copy of the configuration registers
    logic [LEN_W-1:0] field_width_r;
    logic [LEN_W-1:0] min_digits_r;
    logic             zero_pad_r;
    logic             left_justify_r;
    logic             alt_form_r;

    t_char_word pending_chars[$];
    t_char_word exp_word;
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         sender_idle_pct = 0;
    int         recv_stall_pct = 0;

    octal_field_formatter i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_value        (i_value),
        .empty          (empty),
        .pop            (pop),
        .o_char_code    (o_char_code),
        .o_is_last      (o_is_last),
        .o_total_length (o_total_length)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: random stalls on pop
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each popped word against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected word char %h last %b len %0d", $time,
                         o_char_code, o_is_last, o_total_length);
                mismatch_count++;
            end else begin
                exp_word = pending_chars.pop_front();
                if (o_char_code !== exp_word.char_code) begin
                    $display("%0t: char_code exp %h got %h", $time,
                             exp_word.char_code, o_char_code);
                    mismatch_count++;
                end
                if (o_is_last !== exp_word.is_last) begin
                    $display("%0t: is_last exp %b got %b", $time,
                             exp_word.is_last, o_is_last);
                    mismatch_count++;
                end
                if (o_total_length !== exp_word.total_length) begin
                    $display("%0t: total_length exp %0d got %0d", $time,
                             exp_word.total_length, o_total_length);
                    mismatch_count++;
                end
            end
        end
    end

    // Format one value as the block should and queue its characters
    function automatic void format_octal_field(input logic [31:0] v);
        logic [2:0]  digs [DIGIT_N];
        logic [7:0]  line [FIELD_MAX];
        logic [31:0] rest;
        logic [7:0]  pad_ch;
        int          nd, core, total, pad, pos, i;
        rest = v;
        nd = 0;
        do begin
            digs[nd] = rest[2:0];
            nd++;
            rest = rest >> 3;
        end while (rest != 0 && nd < DIGIT_N);

        core = nd;
        if (alt_form_r && v != 0)
            core++;
        if (core < int'(min_digits_r))
            core = min_digits_r;
        if (core > FIELD_MAX)
            core = FIELD_MAX;
        total = (int'(field_width_r) > core) ? int'(field_width_r) : core;
        pad = total - core;
        pad_ch = zero_pad_r ? CH_ZERO : CH_SPACE;

        pos = 0;
        if (!left_justify_r) begin
            for (i = 0; i < pad; i++) begin
                line[pos] = pad_ch;
                pos++;
            end
        end
        for (i = 0; i < core - nd; i++) begin
            line[pos] = CH_ZERO;
            pos++;
        end
        for (i = nd - 1; i >= 0; i--) begin
            line[pos] = CH_ZERO + 8'(digs[i]);
            pos++;
        end
        if (left_justify_r) begin
            for (i = 0; i < pad; i++) begin
                line[pos] = CH_SPACE;
                pos++;
            end
        end

        for (i = 0; i < total; i++) begin
            pending_chars.push_back('{char_code: line[i], is_last: (i == total - 1),
                                      total_length: (i == total - 1) ? LEN_W'(total)
                                                                     : '0});
        end
    endfunction

    // Push one value; returns at the falling edge after it was taken
    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(99) < sender_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (full);
        format_octal_field(v);
        @(negedge i_clk);
    endtask

    // Stop pushing and wait until every expected word has been popped
    task automatic drain_fields;
        push <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input logic [2:0] idx, input logic [LEN_W-1:0] data);
        drain_fields();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_FIELD_WIDTH:  field_width_r  = data;
            REG_MIN_DIGITS:   min_digits_r   = data;
            REG_ZERO_PAD:     zero_pad_r     = data[0];
            REG_LEFT_JUSTIFY: left_justify_r = data[0];
            REG_ALT_FORM:     alt_form_r     = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mix of zero, all ones, small numbers, digit boundaries and full range
    function automatic logic [31:0] random_value();
        int k;
        k = $urandom_range(31);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 32'($urandom_range(0, 63));
            3:       return 32'(1) << k;
            4:       return (32'(1) << k) - 1;
            default: return $urandom;
        endcase
    endfunction

    // New random setting; mostly short fields, sometimes the extremes
    task automatic randomize_config;
        int r;
        r = $urandom_range(7);
        write_reg(REG_FIELD_WIDTH, (r == 0) ? LEN_W'(FIELD_MAX) :
                                   (r < 3) ? '0 : LEN_W'($urandom_range(1, 16)));
        r = $urandom_range(7);
        write_reg(REG_MIN_DIGITS, (r == 0) ? LEN_W'(FIELD_MAX) :
                                  (r < 4) ? '0 : LEN_W'($urandom_range(1, 12)));
        write_reg(REG_ZERO_PAD,     LEN_W'($urandom_range(63)));
        write_reg(REG_LEFT_JUSTIFY, LEN_W'($urandom_range(63)));
        write_reg(REG_ALT_FORM,     LEN_W'($urandom_range(63)));
    endtask

    // Reset values of all registers: plain octal
    task automatic test_reset_defaults;
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'o7);
        send_value(32'o10);
        send_value(32'o12345670);
        send_value(32'hFFFF_FFFF);
        drain_fields();
    endtask

    // Padding, justification, alternate form and precision
    task automatic test_format_options;
        int k;
        // right aligned, space then zero padding
        write_reg(REG_FIELD_WIDTH, 6'd10);
        send_value(32'o777);
        write_reg(REG_ZERO_PAD, 6'd1);
        send_value(32'o777);
        // left justified pads with spaces even with zero_pad on
        write_reg(REG_LEFT_JUSTIFY, 6'd1);
        send_value(32'o777);
        write_reg(REG_LEFT_JUSTIFY, 6'd0);
        write_reg(REG_ZERO_PAD, 6'd0);
        // alternate form: a leading zero added, nothing added to zero, also with precision
        write_reg(REG_FIELD_WIDTH, 6'd0);
        write_reg(REG_ALT_FORM, 6'd1);
        send_value(32'd0);
        send_value(32'o10);
        send_value(32'hFFFF_FFFF);
        write_reg(REG_MIN_DIGITS, 6'd4);
        send_value(32'o7);
        write_reg(REG_ALT_FORM, 6'd0);
        // precision together with zero padding
        write_reg(REG_MIN_DIGITS, 6'd5);
        write_reg(REG_FIELD_WIDTH, 6'd12);
        write_reg(REG_ZERO_PAD, 6'd1);
        send_value(32'o17);
        // width not above the text length
        write_reg(REG_MIN_DIGITS, 6'd0);
        write_reg(REG_FIELD_WIDTH, 6'd3);
        send_value(32'hFFFF_FFFF);
        write_reg(REG_FIELD_WIDTH, 6'd11);
        send_value(32'hFFFF_FFFF);
        // largest width and precision
        write_reg(REG_FIELD_WIDTH, LEN_W'(FIELD_MAX));
        send_value(32'hFFFF_FFFF);
        write_reg(REG_ZERO_PAD, 6'd0);
        send_value(32'd0);
        write_reg(REG_LEFT_JUSTIFY, 6'd1);
        send_value(32'o123);
        write_reg(REG_FIELD_WIDTH, 6'd0);
        write_reg(REG_LEFT_JUSTIFY, 6'd0);
        write_reg(REG_MIN_DIGITS, LEN_W'(FIELD_MAX));
        send_value(32'd5);
        // one-bit registers keep only bit 0
        write_reg(REG_MIN_DIGITS, 6'd0);
        write_reg(REG_ZERO_PAD, 6'h3E);
        write_reg(REG_FIELD_WIDTH, 6'd6);
        send_value(32'o42);
        // writes to unused indexes change nothing
        for (k = 1; k <= 3; k++)
            write_reg(REG_ALT_FORM + 3'(k), 6'h3F);
        send_value(32'o42);
        send_value(32'o1);
        drain_fields();
    endtask

    // Random values under changing settings with the given idling
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        int n;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        for (n = 0; n < count; n++) begin
            if (n % 14 == 0)
                randomize_config();
            send_value(random_value());
        end
        drain_fields();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        push       = 1'b0;
        i_value    = '0;
        field_width_r  = '0;
        min_digits_r   = '0;
        zero_pad_r     = 1'b0;
        left_justify_r = 1'b0;
        alt_form_r     = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_format_options();
        test_random_traffic(0, 0, 60);
        test_random_traffic(74, 0, 55);
        test_random_traffic(0, 74, 55);
        test_random_traffic(32, 32, 55);

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        drain_fields();
        repeat (FIELD_MAX) @(negedge i_clk);
        if (mismatch_count == 0 && pending_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
src/ofmt_pkg.sv
src/ofmt_front.sv
src/ofmt_dq.sv
src/ofmt_back.sv
src/octal_field_formatter.sv
tb/octal_field_formatter_test.sv
